// ----- rtl/core/avtn_pkg.sv -----
// avtn_pkg: shared types and constants for the A/V timestamp normaliser.
// No dependencies; used by avtn_track_step and av_timestamp_normalizer.
package avtn_pkg;

    // Per-track step state, time and last raw input kept apart
    typedef struct packed {
        logic [31:0] prev_stamp;
        logic [15:0] prev_step;
        logic [7:0]  resync_count;
    } t_trk;

    typedef enum logic [1:0] {
        CFG_MAX_JUMP   = 2'd0,
        CFG_DRIFT      = 2'd1,
        CFG_INPUT_GAP  = 2'd2,
        CFG_CLAMP_EN   = 2'd3
    } t_cfg_idx;

    localparam logic [15:0] JUMP_DEFAULT       = 16'd300;
    localparam logic [15:0] DRIFT_DEFAULT      = 16'd300;
    localparam logic [15:0] GAP_DEFAULT        = 16'd5000;
    localparam logic [7:0]  SYNC_PENDING_LIMIT = 8'd3;
    localparam logic [7:0]  COUNT_MAX          = 8'd255;
    localparam logic [15:0] STEP_RESET         = 16'd1;
    localparam logic [7:0]  VID_COUNT_RESET    = 8'd0;
    localparam logic [7:0]  AUD_COUNT_RESET    = 8'd1;

endpackage

// ----- rtl/core/avtn_track_step.sv -----
// avtn_track_step: step between raw stamps of one track, with resync counting.
// Depends on avtn_pkg (t_trk, COUNT_MAX).
module avtn_track_step (
    input  avtn_pkg::t_trk      i_trk,
    input  logic [31:0]         i_raw,
    input  logic [15:0]         i_limit,
    output avtn_pkg::t_trk      o_trk,
    output logic signed [16:0]  o_step
);

    logic        fwd;
    logic [31:0] step_dist;
    logic        big;

    assign fwd       = (i_raw >= i_trk.prev_stamp);
    assign step_dist = fwd ? (i_raw - i_trk.prev_stamp) : (i_trk.prev_stamp - i_raw);
    assign big       = (step_dist > {16'd0, i_limit});

    always_comb begin
        o_trk  = i_trk;
        o_step = '0;
        if (i_trk.prev_stamp == 32'd0) begin
            // first stamp only anchors the track
            o_trk.prev_stamp = i_raw;
        end else begin
            o_trk.prev_stamp = i_raw;
            if (big) begin
                if (i_trk.resync_count != avtn_pkg::COUNT_MAX) begin
                    o_trk.resync_count = i_trk.resync_count + 8'd1;
                end
                o_step = (i_trk.prev_step == 16'd0) ? 17'sd1
                                                    : $signed({1'b0, i_trk.prev_step});
            end else if (fwd) begin
                o_trk.prev_step = (step_dist == 32'd0) ? 16'd1 : step_dist[15:0];
                o_step = $signed({1'b0, step_dist[15:0]});
            end else begin
                o_step = -$signed({1'b0, step_dist[15:0]});
            end
        end
    end

endmodule

// ----- rtl/core/av_timestamp_normalizer.sv -----
// av_timestamp_normalizer: top level, per-track relative time with A/V sync and clamp.
// Depends on avtn_pkg and avtn_track_step.
//
// Usage:
//   s_axis carries one raw millisecond stamp per transaction: tdata is raw_ms,
//   tuser is the track (0 video, 1 audio). m_axis returns one transaction per
//   input, the low 32 bits of that track's relative time, in input order.
//   The cfg channel writes the four registers by index (o_cfg_ready is always
//   high); write only while no transaction is in flight.
//   m_axis_tvalid rises when the result register loads the step/sync/clamp
//   result of the transaction that the input register took on acceptance.
//   One transaction per cycle is sustained while m_axis_tready stays high;
//   the state update of each item lands at the same edge as its result, so
//   the next item always sees it.
//   If m_axis_tready is low the result register holds, the input register
//   takes one more transaction, then s_axis_tready drops until space frees.
//   Reset (i_rst_n low, synchronous) clears both tracks, restores register
//   defaults and marks the audio link request pending.
module av_timestamp_normalizer #(
    parameter int TIME_WIDTH = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] raw_ms
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] time_ms
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int DW = TIME_WIDTH + 1;

    // configuration
    logic [15:0] r_max_jump, r_drift, r_gap;
    logic        r_clamp_en;

    // pipeline
    logic        r_in_valid, r_in_kind;
    logic [31:0] r_in_raw;
    logic        r_out_valid;
    logic [31:0] r_out_time;
    logic        adv;

    // track state
    avtn_pkg::t_trk          r_vid, r_aud, n_vid, n_aud;
    logic [31:0]             r_vid_input, r_aud_input, n_vid_input, n_aud_input;
    logic [TIME_WIDTH-1:0]   r_vid_time, r_aud_time, n_vid_time, n_aud_time;

    // step of the stamped track
    avtn_pkg::t_trk          sel_trk, stp_trk;
    logic signed [16:0]      stp;
    logic [31:0]             sel_input;
    logic [TIME_WIDTH-1:0]   sel_time, stepped_time;
    logic [15:0]             limit;
    logic                    chg;

    // after step
    avtn_pkg::t_trk          v1_trk, a1_trk;
    logic [TIME_WIDTH-1:0]   v1_time, a1_time, v2_time, a2_time;
    logic [31:0]             vpi1, api1, gap;
    logic                    sync_go, sync_vid_low, sync_aud_raise;
    logic signed [DW-1:0]    d1, d2, ndrift, pdrift;
    logic                    in1, in2;

    assign o_cfg_ready   = 1'b1;
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_time;

    assign limit     = (r_max_jump == 16'd0) ? avtn_pkg::JUMP_DEFAULT : r_max_jump;
    assign sel_trk   = r_in_kind ? r_aud : r_vid;
    assign sel_input = r_in_kind ? r_aud_input : r_vid_input;
    assign sel_time  = r_in_kind ? r_aud_time : r_vid_time;
    assign chg       = (sel_input != r_in_raw);

    avtn_track_step u_step (
        .i_trk   (sel_trk),
        .i_raw   (r_in_raw),
        .i_limit (limit),
        .o_trk   (stp_trk),
        .o_step  (stp)
    );

    assign stepped_time = sel_time + {{(TIME_WIDTH-17){stp[16]}}, stp};

    assign v1_trk  = (!r_in_kind && chg) ? stp_trk : r_vid;
    assign a1_trk  = (r_in_kind && chg) ? stp_trk : r_aud;
    assign v1_time = (!r_in_kind && chg) ? stepped_time : r_vid_time;
    assign a1_time = (r_in_kind && chg) ? stepped_time : r_aud_time;
    assign vpi1    = r_in_kind ? r_vid_input : r_in_raw;
    assign api1    = r_in_kind ? r_in_raw : r_aud_input;

    assign pdrift = $signed({{(DW-16){1'b0}}, r_drift});
    assign ndrift = -pdrift;

    // audio sync: video drops to audio within drift, audio rises to video beyond it
    assign gap = (api1 >= vpi1) ? (api1 - vpi1) : (vpi1 - api1);
    assign sync_go = r_in_kind && (vpi1 != 32'd0)
                     && ((a1_trk.resync_count != 8'd0) || (v1_trk.resync_count != 8'd0))
                     && !((gap >= {16'd0, r_gap})
                          && (a1_trk.resync_count <= avtn_pkg::SYNC_PENDING_LIMIT));
    assign d1  = $signed({a1_time[TIME_WIDTH-1], a1_time})
               - $signed({v1_time[TIME_WIDTH-1], v1_time});
    assign in1 = (d1 <= pdrift) && (d1 >= ndrift);

    assign sync_vid_low   = sync_go && in1 && d1[DW-1];
    assign sync_aud_raise = sync_go && !in1 && d1[DW-1];
    assign v2_time        = sync_vid_low ? a1_time : v1_time;
    assign a2_time        = sync_aud_raise ? v1_time : a1_time;

    // clamp on post-sync times (video minus audio)
    assign d2  = $signed({v2_time[TIME_WIDTH-1], v2_time})
               - $signed({a2_time[TIME_WIDTH-1], a2_time});
    assign in2 = (d2 <= pdrift) && (d2 >= ndrift);

    always_comb begin
        n_vid       = v1_trk;
        n_aud       = a1_trk;
        n_vid_input = vpi1;
        n_aud_input = api1;
        if (sync_vid_low) begin
            n_vid.prev_stamp = vpi1;
        end
        if (sync_aud_raise) begin
            n_aud.prev_stamp = api1;
        end
        if (sync_go) begin
            if (a1_trk.resync_count != 8'd0) begin
                n_aud.resync_count = a1_trk.resync_count - 8'd1;
            end
            if (v1_trk.resync_count != 8'd0) begin
                n_vid.resync_count = v1_trk.resync_count - 8'd1;
            end
        end
        n_vid_time = v2_time;
        n_aud_time = a2_time;
        if (r_clamp_en && (api1 != 32'd0) && (vpi1 != 32'd0) && !in2) begin
            if (!d2[DW-1]) begin
                n_vid_time       = a2_time;
                n_vid.prev_stamp = vpi1;
            end else begin
                n_aud_time       = v2_time;
                n_aud.prev_stamp = api1;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_jump <= avtn_pkg::JUMP_DEFAULT;
            r_drift    <= avtn_pkg::DRIFT_DEFAULT;
            r_gap      <= avtn_pkg::GAP_DEFAULT;
            r_clamp_en <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (avtn_pkg::t_cfg_idx'(i_cfg_index))
                avtn_pkg::CFG_MAX_JUMP:  r_max_jump <= i_cfg_data;
                avtn_pkg::CFG_DRIFT:     r_drift    <= i_cfg_data;
                avtn_pkg::CFG_INPUT_GAP: r_gap      <= i_cfg_data;
                avtn_pkg::CFG_CLAMP_EN:  r_clamp_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_kind <= s_axis_tuser;
            r_in_raw  <= s_axis_tdata;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_time <= r_in_kind ? n_aud_time[31:0] : n_vid_time[31:0];
        end
    end

    // track state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vid       <= '{prev_stamp: 32'd0, prev_step: avtn_pkg::STEP_RESET,
                             resync_count: avtn_pkg::VID_COUNT_RESET};
            r_aud       <= '{prev_stamp: 32'd0, prev_step: avtn_pkg::STEP_RESET,
                             resync_count: avtn_pkg::AUD_COUNT_RESET};
            r_vid_input <= '0;
            r_aud_input <= '0;
            r_vid_time  <= '0;
            r_aud_time  <= '0;
        end else if (adv) begin
            r_vid       <= n_vid;
            r_aud       <= n_aud;
            r_vid_input <= n_vid_input;
            r_aud_input <= n_aud_input;
            r_vid_time  <= n_vid_time;
            r_aud_time  <= n_aud_time;
        end
    end

`ifndef SYNTH
    // last good step is never zero on either track
    a_step_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vid.prev_step != 16'd0) && (r_aud.prev_step != 16'd0))
        else $error("prev_step reached zero");

    // an advancing transaction always lands in the result register
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("result register missed a transaction");

    // an empty result register never blocks the input side
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // a stalled result is not overwritten
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !adv)
        else $error("stalled result overwritten");
`endif

endmodule

// ----- tb/av_timestamp_tb_pkg.sv -----
// av_timestamp_tb_pkg: testbench-side names for the stamp track codes.
// No dependencies; used by av_timestamp_checker and tb_av_timestamp_normalizer.
package av_timestamp_tb_pkg;

    typedef enum logic {
        KIND_VIDEO = 1'b0,
        KIND_AUDIO = 1'b1
    } t_stamp_kind;

endpackage

// ----- tb/av_timestamp_checker.sv -----
// av_timestamp_checker: watches the stamp, result and register channels of
// av_timestamp_normalizer, predicts each relative time and compares results.
// Depends on avtn_pkg and av_timestamp_tb_pkg.
module av_timestamp_checker #(
    parameter int TIME_WIDTH = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_stamp_valid,
    input  logic        i_stamp_ready,
    input  logic [31:0] i_stamp_raw,
    input  logic        i_stamp_kind,
    input  logic        i_time_valid,
    input  logic        i_time_ready,
    input  logic [31:0] i_time_ms,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import av_timestamp_tb_pkg::*;

    typedef struct packed {
        logic [31:0]           stamp;
        logic [31:0]           last_raw;
        logic [15:0]           step;
        logic [TIME_WIDTH-1:0] rel_time;
        logic [7:0]            resyncs;
    } t_track;

    t_track      trk [2];
    logic [15:0] jump_ms;
    logic [15:0] drift_ms;
    logic [15:0] gap_ms;
    logic        clamp_en;

    logic [31:0] expected_time_q [$];
    logic [31:0] oldest_time;
    int          mismatches = 0;

    function automatic void reset_model();
        jump_ms  = avtn_pkg::JUMP_DEFAULT;
        drift_ms = avtn_pkg::DRIFT_DEFAULT;
        gap_ms   = avtn_pkg::GAP_DEFAULT;
        clamp_en = 1'b1;
        for (int k = 0; k < 2; k++) begin
            trk[k].stamp    = '0;
            trk[k].last_raw = '0;
            trk[k].step     = avtn_pkg::STEP_RESET;
            trk[k].rel_time = '0;
        end
        trk[KIND_VIDEO].resyncs = avtn_pkg::VID_COUNT_RESET;
        trk[KIND_AUDIO].resyncs = avtn_pkg::AUD_COUNT_RESET;
    endfunction

    function automatic void write_setting(logic [1:0] index, logic [15:0] value);
        case (avtn_pkg::t_cfg_idx'(index))
            avtn_pkg::CFG_MAX_JUMP:  jump_ms  = value;
            avtn_pkg::CFG_DRIFT:     drift_ms = value;
            avtn_pkg::CFG_INPUT_GAP: gap_ms   = value;
            avtn_pkg::CFG_CLAMP_EN:  clamp_en = value[0];
            default: ;
        endcase
    endfunction

    // exact distance of two signed times
    function automatic logic [TIME_WIDTH:0] time_dist(logic [TIME_WIDTH-1:0] a,
                                                      logic [TIME_WIDTH-1:0] b);
        logic signed [TIME_WIDTH:0] diff;
        diff = $signed({a[TIME_WIDTH-1], a}) - $signed({b[TIME_WIDTH-1], b});
        return diff[TIME_WIDTH] ? -diff : diff;
    endfunction

    function automatic logic within_drift(logic [TIME_WIDTH-1:0] a, logic [TIME_WIDTH-1:0] b);
        return time_dist(a, b) <= {{(TIME_WIDTH - 15){1'b0}}, drift_ms};
    endfunction

    function automatic void advance_track(t_stamp_kind kind, logic [31:0] raw);
        logic [31:0]           limit;
        logic [31:0]           step_dist;
        logic                  backward;
        logic [TIME_WIDTH-1:0] delta;
        limit = (jump_ms == '0) ? {16'd0, avtn_pkg::JUMP_DEFAULT} : {16'd0, jump_ms};
        delta = '0;
        if (trk[kind].stamp == '0) begin
            if (raw != '0) begin
                trk[kind].stamp = raw;
            end
        end else begin
            backward = raw < trk[kind].stamp;
            step_dist = backward ? trk[kind].stamp - raw : raw - trk[kind].stamp;
            trk[kind].stamp = raw;
            if (step_dist > limit) begin
                // jump: count a resync and reuse the last good forward step
                if (trk[kind].resyncs != avtn_pkg::COUNT_MAX) begin
                    trk[kind].resyncs = trk[kind].resyncs + 8'd1;
                end
                delta = {{(TIME_WIDTH - 16){1'b0}},
                         (trk[kind].step == '0) ? 16'd1 : trk[kind].step};
            end else if (backward) begin
                delta = '0 - {{(TIME_WIDTH - 32){1'b0}}, step_dist};
            end else begin
                trk[kind].step = (step_dist == '0) ? 16'd1 : step_dist[15:0];
                delta = {{(TIME_WIDTH - 32){1'b0}}, step_dist};
            end
        end
        trk[kind].rel_time = trk[kind].rel_time + delta;
    endfunction

    function automatic void pull_audio();
        logic [31:0] gap;
        if (trk[KIND_VIDEO].last_raw == '0) begin
            return;
        end
        if (trk[KIND_AUDIO].resyncs == '0 && trk[KIND_VIDEO].resyncs == '0) begin
            return;
        end
        gap = (trk[KIND_AUDIO].last_raw >= trk[KIND_VIDEO].last_raw)
            ? trk[KIND_AUDIO].last_raw - trk[KIND_VIDEO].last_raw
            : trk[KIND_VIDEO].last_raw - trk[KIND_AUDIO].last_raw;
        if (gap >= {16'd0, gap_ms}
            && trk[KIND_AUDIO].resyncs <= avtn_pkg::SYNC_PENDING_LIMIT) begin
            return;
        end
        if (within_drift(trk[KIND_AUDIO].rel_time, trk[KIND_VIDEO].rel_time)) begin
            if ($signed(trk[KIND_AUDIO].rel_time) < $signed(trk[KIND_VIDEO].rel_time)) begin
                trk[KIND_VIDEO].rel_time = trk[KIND_AUDIO].rel_time;
                trk[KIND_VIDEO].stamp    = trk[KIND_VIDEO].last_raw;
            end
        end else if ($signed(trk[KIND_VIDEO].rel_time) > $signed(trk[KIND_AUDIO].rel_time)) begin
            trk[KIND_AUDIO].rel_time = trk[KIND_VIDEO].rel_time;
            trk[KIND_AUDIO].stamp    = trk[KIND_AUDIO].last_raw;
        end
        for (int k = 0; k < 2; k++) begin
            if (trk[k].resyncs != '0) begin
                trk[k].resyncs = trk[k].resyncs - 8'd1;
            end
        end
    endfunction

    function automatic void clamp_tracks();
        if (!clamp_en || trk[KIND_AUDIO].last_raw == '0 || trk[KIND_VIDEO].last_raw == '0) begin
            return;
        end
        if (within_drift(trk[KIND_VIDEO].rel_time, trk[KIND_AUDIO].rel_time)) begin
            return;
        end
        if ($signed(trk[KIND_VIDEO].rel_time) > $signed(trk[KIND_AUDIO].rel_time)) begin
            trk[KIND_VIDEO].rel_time = trk[KIND_AUDIO].rel_time;
            trk[KIND_VIDEO].stamp    = trk[KIND_VIDEO].last_raw;
        end else begin
            trk[KIND_AUDIO].rel_time = trk[KIND_VIDEO].rel_time;
            trk[KIND_AUDIO].stamp    = trk[KIND_AUDIO].last_raw;
        end
    endfunction

    function automatic logic [31:0] predict_time(t_stamp_kind kind, logic [31:0] raw);
        if (trk[kind].last_raw != raw) begin
            advance_track(kind, raw);
            trk[kind].last_raw = raw;
        end
        if (kind == KIND_AUDIO) begin
            pull_audio();
        end
        clamp_tracks();
        return trk[kind].rel_time[31:0];
    endfunction

    function automatic void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("time_ms mismatch (%s): expected %h, got %h", what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            expected_time_q.delete();
        end else begin
            if (i_time_valid && i_time_ready) begin
                if (expected_time_q.size() == 0) begin
                    report_mismatch("nothing outstanding", 32'h0, i_time_ms);
                end else begin
                    oldest_time = expected_time_q.pop_front();
                    if (oldest_time !== i_time_ms) begin
                        report_mismatch("value", oldest_time, i_time_ms);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                write_setting(i_cfg_index, i_cfg_data);
            end
            if (i_stamp_valid && i_stamp_ready) begin
                expected_time_q.push_back(predict_time(t_stamp_kind'(i_stamp_kind), i_stamp_raw));
            end
        end
        o_pending    <= expected_time_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- tb/tb_av_timestamp_normalizer.sv -----
// tb_av_timestamp_normalizer: drives stamps and register writes into
// av_timestamp_normalizer and gives the verdict; checking is in av_timestamp_checker.
// Depends on avtn_pkg, av_timestamp_tb_pkg and av_timestamp_checker.
module tb_av_timestamp_normalizer;
    import av_timestamp_tb_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    logic        tx_idle = 1'b0;
    logic        rx_idle = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    logic [31:0] cur_raw [2];

    always #10 i_clk = ~i_clk;

    av_timestamp_normalizer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] raw_ms
        .s_axis_tuser  (s_axis_tuser),   // [0] kind
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] time_ms
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    av_timestamp_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stamp_valid (s_axis_tvalid),
        .i_stamp_ready (s_axis_tready),
        .i_stamp_raw   (s_axis_tdata),
        .i_stamp_kind  (s_axis_tuser),
        .i_time_valid  (m_axis_tvalid),
        .i_time_ready  (m_axis_tready),
        .i_time_ms     (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random back-pressure once rx_idle is set, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                hold_done <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= !rx_idle || ($urandom_range(0, 99) >= 20);
            end
        end
    end

    task automatic send_stamp(input t_stamp_kind kind, input logic [31:0] raw);
        while (tx_idle && $urandom_range(0, 99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_setting(input avtn_pkg::t_cfg_idx index, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(input logic [15:0] jump, input logic [15:0] drift,
                             input logic [15:0] gap, input logic clamp);
        wait_drained();
        write_setting(avtn_pkg::CFG_MAX_JUMP, jump);
        write_setting(avtn_pkg::CFG_DRIFT, drift);
        write_setting(avtn_pkg::CFG_INPUT_GAP, gap);
        write_setting(avtn_pkg::CFG_CLAMP_EN, {15'd0, clamp});
        i_cfg_valid <= 1'b0;
    endtask

    // mostly steady streams per track, with jumps, repeats, zeros and noise
    task automatic send_random_stamps(input int count);
        t_stamp_kind kind;
        int          pick;
        logic [31:0] raw;
        for (int n = 0; n < count; n++) begin
            kind = t_stamp_kind'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                cur_raw[kind] = cur_raw[kind] + $urandom_range(1, 250);
            end else if (pick < 63) begin
                cur_raw[kind] = cur_raw[kind] - $urandom_range(1, 250);
            end else if (pick < 71) begin
                cur_raw[kind] = cur_raw[kind] + $urandom_range(251, 70000);
            end else if (pick < 75) begin
                cur_raw[kind] = cur_raw[kind] - $urandom_range(251, 70000);
            end else if (pick < 85) begin
                cur_raw[kind] = cur_raw[kind ^ 1'b1] + $urandom_range(0, 400);
            end else if (pick < 91) begin
                cur_raw[kind] = $urandom();
            end
            raw = (pick >= 91 && pick < 95) ? 32'd0 : cur_raw[kind];
            send_stamp(kind, raw);
        end
    endtask

    initial begin
        cur_raw[KIND_VIDEO] = $urandom();
        cur_raw[KIND_AUDIO] = $urandom();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, no idling
        send_stamp(KIND_VIDEO, 32'd0);
        send_stamp(KIND_AUDIO, 32'd0);
        send_stamp(KIND_VIDEO, 32'd1000);
        send_stamp(KIND_VIDEO, 32'd1000);
        send_stamp(KIND_VIDEO, 32'd1040);
        send_stamp(KIND_VIDEO, 32'd1020);
        send_stamp(KIND_VIDEO, 32'd5000);
        send_stamp(KIND_VIDEO, 32'd4000);
        send_stamp(KIND_VIDEO, 32'd0);
        send_stamp(KIND_VIDEO, 32'd3000);
        send_stamp(KIND_AUDIO, 32'd2000);
        send_stamp(KIND_AUDIO, 32'd2040);
        send_stamp(KIND_AUDIO, 32'd2030);
        send_stamp(KIND_AUDIO, 32'd9000);
        send_stamp(KIND_VIDEO, 32'd3300);
        send_stamp(KIND_AUDIO, 32'hFFFF_FFFF);
        send_stamp(KIND_VIDEO, 32'hFFFF_FFFF);
        send_stamp(KIND_VIDEO, 32'hFFFF_FFF0);
        send_stamp(KIND_AUDIO, 32'd1);
        send_stamp(KIND_VIDEO, 32'd2);

        send_random_stamps(130);
        tx_idle = 1'b1;
        rx_idle <= 1'b1;
        hold_req <= 1'b1;
        send_random_stamps(90);

        // low extremes; jump limit zero falls back to the default
        configure(16'd0, 16'd0, 16'd0, 1'b0);
        for (int n = 0; n < 260; n++) begin
            cur_raw[KIND_VIDEO] = cur_raw[KIND_VIDEO] + $urandom_range(1000, 9000);
            send_stamp(KIND_VIDEO, cur_raw[KIND_VIDEO]);
        end
        // video idle so audio sync stays off and the audio count saturates
        send_stamp(KIND_VIDEO, 32'd0);
        for (int n = 0; n < 260; n++) begin
            cur_raw[KIND_AUDIO] = cur_raw[KIND_AUDIO] + $urandom_range(1000, 9000);
            send_stamp(KIND_AUDIO, cur_raw[KIND_AUDIO]);
        end
        send_random_stamps(100);

        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_random_stamps(120);

        for (int p = 0; p < 2; p++) begin
            configure(16'($urandom_range(20, 2000)), 16'($urandom_range(0, 1000)),
                      16'($urandom_range(0, 20000)), 1'($urandom_range(0, 1)));
            send_random_stamps(80);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
